// File: rtl/rsat_pkg.sv
package rsat_pkg;

   // Table geometry
   localparam int NUM_DIMENSIONS = 8;
   localparam int IDX_W          = (NUM_DIMENSIONS > 1) ? $clog2(NUM_DIMENSIONS) : 1;

   // Field widths fixed by the interface
   localparam int OPCODE_W = 3;
   localparam int DIM_W    = 4;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // The one unbounded dimension: it counts bytes
   localparam logic [DIM_W-1:0] BYTES_DIMENSION = DIM_W'(1);

   localparam logic [VALUE_W-1:0] SHARE_LIMIT_RESET = VALUE_W'(1000000);

   // Opcodes on the request port
   localparam logic [OPCODE_W-1:0] OP_SET   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SUB   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

   // Status codes on the response port
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DIM_W-1:0]    dimension;
      logic [VALUE_W-1:0]  operand_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic                present;
      logic [COUNT_W-1:0]  present_count;
   } rsp_type;

   // Decoded operation kind
   typedef enum logic [2:0] {
      KIND_SET,
      KIND_CLEAR,
      KIND_ADD,
      KIND_SUB,
      KIND_READ,
      KIND_BAD
   } kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      kind_type           kind;
      logic               in_range;
      logic               share;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

// File: rtl/rsat_front.sv
module rsat_front (
   input  logic             req_push,
   input  rsat_pkg::req_type req_data,
   output logic             req_full,
   input  logic             q_full,
   output logic             q_push,
   output rsat_pkg::cmd_type q_cmd
);

   logic [rsat_pkg::DIM_W:0] dim_ext;
   rsat_pkg::kind_type       kind;

   // Pass backpressure straight from the queue
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // Classify the dimension
   assign dim_ext        = {1'b0, req_data.dimension};
   assign q_cmd.in_range = dim_ext < (rsat_pkg::DIM_W + 1)'(rsat_pkg::NUM_DIMENSIONS);
   assign q_cmd.share    = req_data.dimension != rsat_pkg::BYTES_DIMENSION;
   assign q_cmd.idx      = req_data.dimension[rsat_pkg::IDX_W-1:0];
   assign q_cmd.value    = req_data.operand_value;
   assign q_cmd.kind     = kind;

   // Decode the opcode; unknown codes become a bad command
   always_comb begin
      unique case (req_data.opcode)
         rsat_pkg::OP_SET:   kind = rsat_pkg::KIND_SET;
         rsat_pkg::OP_CLEAR: kind = rsat_pkg::KIND_CLEAR;
         rsat_pkg::OP_ADD:   kind = rsat_pkg::KIND_ADD;
         rsat_pkg::OP_SUB:   kind = rsat_pkg::KIND_SUB;
         rsat_pkg::OP_READ:  kind = rsat_pkg::KIND_READ;
         default:            kind = rsat_pkg::KIND_BAD;
      endcase
   end

endmodule

// File: rtl/rsat_queue.sv
module rsat_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsat_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output rsat_pkg::cmd_type pop_cmd,
   output logic              empty
);

   rsat_pkg::cmd_type             entries_ff [rsat_pkg::QUEUE_DEPTH];
   logic [rsat_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rsat_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rsat_pkg::QCNT_W-1:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign full    = count_ff == rsat_pkg::QCNT_W'(rsat_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == rsat_pkg::QPTR_W'(rsat_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rsat_pkg::QPTR_W'(rsat_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/rsat_back.sv
module rsat_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  rsat_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsat_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [rsat_pkg::VALUE_W-1:0] csr_data
);

   logic [rsat_pkg::VALUE_W-1:0]        amounts_ff [rsat_pkg::NUM_DIMENSIONS];
   logic [rsat_pkg::NUM_DIMENSIONS-1:0] mask_ff, mask_in;
   logic [rsat_pkg::VALUE_W-1:0]        limit_ff, limit_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rsat_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [rsat_pkg::VALUE_W-1:0] cur;
   logic [rsat_pkg::VALUE_W:0]   sum;
   logic [rsat_pkg::VALUE_W-1:0] diff;
   logic [rsat_pkg::VALUE_W-1:0] wr_value;
   logic                         wr_en;
   logic                         here, here_after;
   logic [rsat_pkg::STATUS_W-1:0] status;
   logic [rsat_pkg::COUNT_W-1:0]  count;

   assign csr_ready = 1'b1;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Take the next command once the output register is free
   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_pop);

   assign cur  = amounts_ff[q_cmd.idx];
   assign here = q_cmd.in_range && mask_ff[q_cmd.idx];
   assign sum  = {1'b0, cur} + {1'b0, q_cmd.value};
   assign diff = cur - q_cmd.value;

   // Carry out the operation on the addressed entry
   always_comb begin
      status   = rsat_pkg::ST_OK;
      wr_en    = 1'b0;
      wr_value = q_cmd.value;
      mask_in  = mask_ff;
      unique case (q_cmd.kind)
         rsat_pkg::KIND_SET: begin
            if (!q_cmd.in_range || (q_cmd.share && q_cmd.value > limit_ff)) begin
               status = rsat_pkg::ST_INVALID;
            end else begin
               wr_en              = 1'b1;
               mask_in[q_cmd.idx] = 1'b1;
            end
         end
         rsat_pkg::KIND_CLEAR: begin
            if (q_cmd.in_range) begin
               wr_en              = 1'b1;
               wr_value           = '0;
               mask_in[q_cmd.idx] = 1'b0;
            end
         end
         rsat_pkg::KIND_ADD: begin
            if (!here) begin
               status = rsat_pkg::ST_INVALID;
            end else if (sum[rsat_pkg::VALUE_W]) begin
               status = rsat_pkg::ST_OVERFLOW;
            end else if (q_cmd.share && sum[rsat_pkg::VALUE_W-1:0] > limit_ff) begin
               status = rsat_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_value = sum[rsat_pkg::VALUE_W-1:0];
            end
         end
         rsat_pkg::KIND_SUB: begin
            if (!here) begin
               status = rsat_pkg::ST_INVALID;
            end else if (cur < q_cmd.value) begin
               status = rsat_pkg::ST_UNDERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_value = diff;
            end
         end
         rsat_pkg::KIND_READ: begin
            status = rsat_pkg::ST_OK;
         end
         default: begin
            status = rsat_pkg::ST_INVALID;
         end
      endcase
   end

   // Count present entries after the update in the 4-bit field
   always_comb begin
      count = '0;
      for (int i = 0; i < rsat_pkg::NUM_DIMENSIONS; i++) begin
         count = count + rsat_pkg::COUNT_W'(mask_in[i]);
      end
   end

   // Build the response beat from the state after the step
   assign here_after = q_cmd.in_range && mask_in[q_cmd.idx];
   always_comb begin
      rsp_in.status        = status;
      rsp_in.read_value    = here_after ? (wr_en ? wr_value : cur) : '0;
      rsp_in.present       = here_after;
      rsp_in.present_count = count;
   end

   // Hold or advance the output register
   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         limit_ff     <= rsat_pkg::SHARE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            mask_ff <= mask_in;
         end
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Absent entries are never read out, so the amounts need no reset
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
         if (wr_en) begin
            amounts_ff[q_cmd.idx] <= wr_value;
         end
      end
   end

endmodule

// File: rtl/resource_share_accounting_table.sv
// Resource share accounting table: eight 64-bit amounts with a presence mask,
// driven by set, clear, add, subtract and read requests. Dimension 1 counts
// bytes without bound; every other dimension is capped by the share limit
// register (reset 1000000), written on the csr_ port; the user must write it
// only while idle, as the block itself does not enforce that. Each request
// returns one response beat with a status, the addressed amount and presence
// after the step, and the number of present dimensions. Requests are queued,
// executed once the back end's output register is free, and shown on the rsp_
// port until taken. While responses are taken the block sustains one request
// per cycle, reading, modifying and writing a table entry as it pops a command.
// Up to two requests wait in the command queue while a response is not taken.
module resource_share_accounting_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  rsat_pkg::req_type             req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output rsat_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rsat_pkg::VALUE_W-1:0]  csr_data
);

   logic              q_full, q_push, q_empty, q_pop;
   rsat_pkg::cmd_type push_cmd, pop_cmd;

   rsat_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   rsat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   rsat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule

// File: rtl/rsat_checker.sv
module rsat_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input rsat_pkg::rsp_type rsp_data
);

   // Reset leaves no response waiting and room for requests
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("response or full flag after reset");

   // A waiting beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("response beat changed while stalled");

   // An absent dimension reads as zero
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.present) |-> (rsp_data.read_value == '0))
      else $error("absent dimension with nonzero value");

   // A present dimension implies a nonzero count, unless the count wrapped
   a_count_present: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.present) |->
         ((rsp_data.present_count != '0) || (rsat_pkg::NUM_DIMENSIONS == 16)))
      else $error("present dimension with zero count");

   // The count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ((rsp_data.present_count <= rsat_pkg::COUNT_W'(rsat_pkg::NUM_DIMENSIONS)) ||
          (rsat_pkg::NUM_DIMENSIONS >= 16)))
      else $error("present count above table size");

endmodule

bind resource_share_accounting_table rsat_checker u_rsat_checker (.*);

// File: verif/resource_share_accounting_table_test.sv
`timescale 1ns / 1ps

// Mirror of the accounting table; predicts each response and checks it on arrival
class share_ledger;
   logic [rsat_pkg::VALUE_W-1:0]        amounts [rsat_pkg::NUM_DIMENSIONS];
   logic [rsat_pkg::NUM_DIMENSIONS-1:0] presence;
   logic [rsat_pkg::VALUE_W-1:0]        limit;
   rsat_pkg::rsp_type                   expected_rsp [$];
   int unsigned                         errors;

   function new();
      foreach (amounts[i]) amounts[i] = '0;
      presence = '0;
      limit    = rsat_pkg::SHARE_LIMIT_RESET;
      errors   = 0;
   endfunction

   // Apply one request to the mirror and return the response it should give
   function rsat_pkg::rsp_type account_step(rsat_pkg::req_type r);
      int unsigned                   d;
      logic                          in_range;
      logic                          share;
      logic                          here;
      logic [rsat_pkg::VALUE_W:0]    total;
      logic [rsat_pkg::STATUS_W-1:0] st;
      rsat_pkg::rsp_type             res;
      d        = r.dimension;
      in_range = d < rsat_pkg::NUM_DIMENSIONS;
      share    = r.dimension != rsat_pkg::BYTES_DIMENSION;
      here     = in_range && presence[d];
      st       = rsat_pkg::ST_OK;
      case (r.opcode)
         rsat_pkg::OP_SET: begin
            if (!in_range || (share && r.operand_value > limit)) begin
               st = rsat_pkg::ST_INVALID;
            end else begin
               amounts[d]  = r.operand_value;
               presence[d] = 1'b1;
            end
         end
         rsat_pkg::OP_CLEAR: begin
            // out of range is silently ignored
            if (in_range) begin
               amounts[d]  = '0;
               presence[d] = 1'b0;
            end
         end
         rsat_pkg::OP_ADD: begin
            if (!here) begin
               st = rsat_pkg::ST_INVALID;
            end else begin
               total = {1'b0, amounts[d]} + {1'b0, r.operand_value};
               if (total[rsat_pkg::VALUE_W] ||
                   (share && total[rsat_pkg::VALUE_W-1:0] > limit)) begin
                  st = rsat_pkg::ST_OVERFLOW;
               end else begin
                  amounts[d] = total[rsat_pkg::VALUE_W-1:0];
               end
            end
         end
         rsat_pkg::OP_SUB: begin
            if (!here) begin
               st = rsat_pkg::ST_INVALID;
            end else if (amounts[d] < r.operand_value) begin
               st = rsat_pkg::ST_UNDERFLOW;
            end else begin
               amounts[d] = amounts[d] - r.operand_value;
            end
         end
         rsat_pkg::OP_READ: begin
         end
         default: begin
            st = rsat_pkg::ST_INVALID;
         end
      endcase
      here              = in_range && presence[d];
      res.status        = st;
      res.read_value    = here ? amounts[d] : '0;
      res.present       = here;
      res.present_count = rsat_pkg::COUNT_W'($countones(presence));
      return res;
   endfunction

   function void note_request(rsat_pkg::req_type r);
      expected_rsp.push_back(account_step(r));
   endfunction

   function void check_response(rsat_pkg::rsp_type got);
      rsat_pkg::rsp_type exp;
      if (expected_rsp.size() == 0) begin
         $error("response beat with nothing outstanding: %p", got);
         errors++;
         return;
      end
      exp = expected_rsp.pop_front();
      if (got.status !== exp.status) begin
         $error("status: expected %0d, got %0d", exp.status, got.status);
         errors++;
      end
      if (got.read_value !== exp.read_value) begin
         $error("read_value: expected %h, got %h", exp.read_value, got.read_value);
         errors++;
      end
      if (got.present !== exp.present) begin
         $error("present: expected %0d, got %0d", exp.present, got.present);
         errors++;
      end
      if (got.present_count !== exp.present_count) begin
         $error("present_count: expected %0d, got %0d", exp.present_count,
                got.present_count);
         errors++;
      end
   endfunction
endclass

module resource_share_accounting_table_test;

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                         clock;
   logic                         reset;
   logic                         req_push;
   logic                         req_full;
   rsat_pkg::req_type            req_data;
   logic                         rsp_empty;
   logic                         rsp_pop;
   rsat_pkg::rsp_type            rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [rsat_pkg::VALUE_W-1:0] csr_data;

   share_ledger board = new();
   int unsigned cycle_count = 0;
   bit          tx_burst = 1'b0;

   resource_share_accounting_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic rsat_pkg::req_type make_request(
         logic [rsat_pkg::OPCODE_W-1:0] op,
         logic [rsat_pkg::DIM_W-1:0]    dim,
         logic [rsat_pkg::VALUE_W-1:0]  val);
      rsat_pkg::req_type r;
      r.opcode        = op;
      r.dimension     = dim;
      r.operand_value = val;
      return r;
   endfunction

   // Mostly legal traffic on in-range dimensions, with values aimed at the edges
   function automatic rsat_pkg::req_type random_request();
      rsat_pkg::req_type            r;
      int unsigned                  pick;
      logic [rsat_pkg::VALUE_W-1:0] cur;
      logic [rsat_pkg::VALUE_W-1:0] lim;
      logic [rsat_pkg::VALUE_W-1:0] wobble;
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 24) == 0)
         r.opcode = rsat_pkg::OPCODE_W'(rsat_pkg::OP_READ + 1 + $urandom_range(0, 2));
      else if (pick < 5)  r.opcode = rsat_pkg::OP_SET;
      else if (pick < 7)  r.opcode = rsat_pkg::OP_CLEAR;
      else if (pick < 12) r.opcode = rsat_pkg::OP_ADD;
      else if (pick < 17) r.opcode = rsat_pkg::OP_SUB;
      else                r.opcode = rsat_pkg::OP_READ;
      if ($urandom_range(0, 9) == 0)
         r.dimension = rsat_pkg::DIM_W'($urandom_range(rsat_pkg::NUM_DIMENSIONS, 15));
      else if ($urandom_range(0, 2) == 0)
         r.dimension = rsat_pkg::BYTES_DIMENSION;
      else
         r.dimension = rsat_pkg::DIM_W'($urandom_range(0, rsat_pkg::NUM_DIMENSIONS - 1));
      cur    = (r.dimension < rsat_pkg::NUM_DIMENSIONS) ? board.amounts[r.dimension] : '0;
      lim    = board.limit;
      wobble = rsat_pkg::VALUE_W'($urandom_range(0, 2)) - rsat_pkg::VALUE_W'(1);
      case ($urandom_range(0, 7))
         0:       r.operand_value = '0;
         1:       r.operand_value = {$urandom, $urandom};
         2:       r.operand_value = '1 - rsat_pkg::VALUE_W'($urandom_range(0, 3));
         3:       r.operand_value = lim + wobble;
         4:       r.operand_value = cur + wobble;
         5:       r.operand_value = lim - cur + wobble;
         6:       r.operand_value = rsat_pkg::VALUE_W'($urandom_range(0, 1000));
         default: r.operand_value = rsat_pkg::VALUE_W'($urandom);
      endcase
      return r;
   endfunction

   // Offer one beat after a random gap; leave push high on return
   task automatic send_item(input rsat_pkg::req_type item);
      int unsigned gap;
      if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full !== 1'b0);
      board.note_request(item);
   endtask

   // Hold off requests until every outstanding response has been taken
   task automatic drain_table();
      req_push <= 1'b0;
      do @(posedge clock); while (board.expected_rsp.size() != 0);
   endtask

   task automatic write_limit(input logic [rsat_pkg::VALUE_W-1:0] value);
      drain_table();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.limit = value;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_item(random_request());
   endtask

   task automatic run_directed();
      logic [rsat_pkg::VALUE_W-1:0] lim;
      logic [rsat_pkg::DIM_W-1:0]   bytes_dim;
      lim       = rsat_pkg::SHARE_LIMIT_RESET;
      bytes_dim = rsat_pkg::BYTES_DIMENSION;
      // absent dimension: read gives zero, add and subtract refuse
      send_item(make_request(rsat_pkg::OP_READ, 4'd0, '0));
      send_item(make_request(rsat_pkg::OP_ADD, 4'd0, 64'd5));
      send_item(make_request(rsat_pkg::OP_SUB, 4'd2, 64'd5));
      // share at the limit and just above
      send_item(make_request(rsat_pkg::OP_SET, 4'd0, lim));
      send_item(make_request(rsat_pkg::OP_SET, 4'd2, lim + 64'd1));
      // bytes dimension is unbounded but an add still overflows at 64 bits
      send_item(make_request(rsat_pkg::OP_SET, bytes_dim, '1));
      send_item(make_request(rsat_pkg::OP_ADD, bytes_dim, 64'd1));
      send_item(make_request(rsat_pkg::OP_ADD, 4'd0, 64'd1));
      send_item(make_request(rsat_pkg::OP_SUB, 4'd0, lim + 64'd1));
      send_item(make_request(rsat_pkg::OP_SUB, 4'd0, lim));
      send_item(make_request(rsat_pkg::OP_ADD, 4'd0, lim >> 1));
      send_item(make_request(rsat_pkg::OP_SET, 4'd7, '0));
      // out-of-range dimensions
      send_item(make_request(rsat_pkg::OP_SET,
                             rsat_pkg::DIM_W'(rsat_pkg::NUM_DIMENSIONS), 64'd5));
      send_item(make_request(rsat_pkg::OP_CLEAR, '1, '0));
      send_item(make_request(rsat_pkg::OP_READ, 4'd12, '1));
      // unknown opcodes
      send_item(make_request(rsat_pkg::OP_READ + 3'd1, 4'd0, '0));
      send_item(make_request(rsat_pkg::OP_READ + 3'd2, bytes_dim, '1));
      send_item(make_request(rsat_pkg::OP_READ + 3'd3, '1, '1));
      send_item(make_request(rsat_pkg::OP_CLEAR, 4'd0, '1));
      send_item(make_request(rsat_pkg::OP_SUB, bytes_dim, '1));
      send_item(make_request(rsat_pkg::OP_ADD, bytes_dim, lim + 64'd5));
      // fill the table so the count reaches its top
      send_item(make_request(rsat_pkg::OP_SET, 4'd0, lim));
      for (int d = 2; d < rsat_pkg::NUM_DIMENSIONS - 1; d++)
         send_item(make_request(rsat_pkg::OP_SET, rsat_pkg::DIM_W'(d),
                                rsat_pkg::VALUE_W'($urandom_range(0, 1000000))));
   endtask

   // Response side: random stalls, with calm stretches of back-to-back pops
   initial begin : response_side
      int unsigned stall;
      bit          rx_burst;
      rsp_pop  = 1'b0;
      rx_burst = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         board.check_response(rsp_data);
      end
   end

   initial begin : stimulus
      logic [rsat_pkg::VALUE_W-1:0] phase_limit [5];
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(45);
      drain_table();
      run_random(45);

      // walk the share limit through its extremes and some middle values
      phase_limit[0] = '0;
      phase_limit[1] = '1;
      phase_limit[2] = rsat_pkg::VALUE_W'(1000);
      phase_limit[3] = {$urandom, $urandom};
      phase_limit[4] = rsat_pkg::SHARE_LIMIT_RESET;
      for (int p = 0; p < 5; p++) begin
         write_limit(phase_limit[p]);
         run_random(85);
      end

      // let the last responses come home
      req_push <= 1'b0;
      while (board.expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
